// ----- sv/crs_pkg.sv -----
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types, codes and helpers for the call recovery supervisor.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int TIME_BITS = 48;
    localparam int CFG_BITS  = 32;
    localparam int CNT_BITS  = 8;
    localparam int CMP_BITS  = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CFG_BITS-1:0]  cfg_word_t;
    typedef logic [CNT_BITS-1:0]  count_t;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_OBSERVE = 2'd1,
        OP_RECORD  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        DISP_IDLE      = 3'd0,
        DISP_SINGLE    = 3'd1,
        DISP_UNKNOWN   = 3'd2,
        DISP_MULTIPLE  = 3'd3,
        DISP_EMERGENCY = 3'd4
    } disp_t;

    typedef enum logic [2:0] {
        DEC_WAIT         = 3'd0,
        DEC_REQUEST      = 3'd1,
        DEC_COMPLETE     = 3'd2,
        DEC_COMPLETE_LAG = 3'd3,
        DEC_EMERGENCY    = 3'd4,
        DEC_EXTERNAL     = 3'd5,
        DEC_UNVERIFIED   = 3'd6,
        DEC_FAIL         = 3'd7
    } dec_t;

    typedef enum logic [2:0] {
        REG_IDLE_CONFIRM   = 3'd0,
        REG_AUDIO_LAG_MAX  = 3'd1,
        REG_SINGLE_CONFIRM = 3'd2,
        REG_UNKNOWN_MAX    = 3'd3,
        REG_RETRY_INTERVAL = 3'd4,
        REG_TOTAL_MAX      = 3'd5,
        REG_MAX_ATTEMPTS   = 3'd6
    } reg_index_t;

    typedef struct packed {
        cfg_word_t idle_confirm;
        cfg_word_t audio_lag;
        cfg_word_t single_confirm;
        cfg_word_t unknown_max;
        cfg_word_t retry_interval;
        cfg_word_t total_max;
        count_t    max_attempts;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] disposition;
        logic       audio_normal;
        time_t      now_ms;
    } item_t;

    typedef struct packed {
        dec_t decision;
        logic attempt_accepted;
    } result_t;

    // a - b, clamped at zero, compared against a threshold
    function automatic logic sat_ge(time_t a, time_t b, cfg_word_t c);
        logic [CMP_BITS-1:0] d;
        d = CMP_BITS'(a - b);
        return (a >= b) ? (d >= CMP_BITS'(c)) : (c == '0);
    endfunction

endpackage

// ----- sv/crs_cfg.sv -----
// ----------------------------------------------------------------------------
// crs_cfg
// Configuration registers; zero is stored as one where the limit needs it.
// ----------------------------------------------------------------------------
module crs_cfg
    import crs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  cfg_word_t       cfg_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    function automatic cfg_word_t at_least_one(cfg_word_t v);
        return (v == '0) ? cfg_word_t'(1) : v;
    endfunction

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_IDLE_CONFIRM:   cfg_next.idle_confirm   = cfg_data;
                REG_AUDIO_LAG_MAX:  cfg_next.audio_lag      = cfg_data;
                REG_SINGLE_CONFIRM: cfg_next.single_confirm = cfg_data;
                REG_UNKNOWN_MAX:    cfg_next.unknown_max    = at_least_one(cfg_data);
                REG_RETRY_INTERVAL: cfg_next.retry_interval = at_least_one(cfg_data);
                REG_TOTAL_MAX:      cfg_next.total_max      = at_least_one(cfg_data);
                REG_MAX_ATTEMPTS:
                begin
                    cfg_next.max_attempts = (cfg_data[CNT_BITS-1:0] == '0) ?
                                            count_t'(1) : cfg_data[CNT_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_confirm   <= '0;
            cfg_reg.audio_lag      <= '0;
            cfg_reg.single_confirm <= '0;
            cfg_reg.unknown_max    <= cfg_word_t'(1);
            cfg_reg.retry_interval <= cfg_word_t'(1);
            cfg_reg.total_max      <= cfg_word_t'(1);
            cfg_reg.max_attempts   <= count_t'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/crs_core.sv -----
// ----------------------------------------------------------------------------
// crs_core
// Supervisor state and the single-pass decision logic for one word.
// ----------------------------------------------------------------------------
module crs_core
    import crs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic   running_reg,       running_next;
    time_t  start_time_reg,    start_time_next;
    time_t  last_obs_time_reg, last_obs_time_next;
    time_t  idle_since_reg,    idle_since_next;
    logic   idle_valid_reg,    idle_valid_next;
    time_t  single_since_reg,  single_since_next;
    logic   single_valid_reg,  single_valid_next;
    time_t  unknown_since_reg, unknown_since_next;
    logic   unknown_valid_reg, unknown_valid_next;
    time_t  last_attempt_reg,  last_attempt_next;
    logic   attempt_valid_reg, attempt_valid_next;
    count_t attempt_count_reg, attempt_count_next;

    time_t now;
    time_t idle_base;
    time_t single_base;
    time_t unknown_base;
    logic  obs_ok;
    logic  idle_ok;
    logic  lag_ok;
    logic  single_ok;
    logic  unknown_ok;
    logic  retry_ok;
    logic  total_ok;
    logic  below_limit;
    dec_t  timeout_dec;

    assign now          = item.now_ms;
    assign idle_base    = idle_valid_reg    ? idle_since_reg    : now;
    assign single_base  = single_valid_reg  ? single_since_reg  : now;
    assign unknown_base = unknown_valid_reg ? unknown_since_reg : now;

    assign obs_ok      = running_reg && (now >= last_obs_time_reg) && (now >= start_time_reg);
    assign idle_ok     = sat_ge(now, idle_base, cfg.idle_confirm);
    assign lag_ok      = idle_ok && sat_ge(now, idle_base, cfg.audio_lag);
    assign single_ok   = sat_ge(now, single_base, cfg.single_confirm);
    assign unknown_ok  = sat_ge(now, unknown_base, cfg.unknown_max);
    assign retry_ok    = attempt_valid_reg && sat_ge(now, last_attempt_reg, cfg.retry_interval);
    assign total_ok    = sat_ge(now, start_time_reg, cfg.total_max);
    assign below_limit = attempt_count_reg < cfg.max_attempts;
    assign timeout_dec = total_ok ? DEC_FAIL : DEC_WAIT;

    always_comb
    begin
        running_next       = running_reg;
        start_time_next    = start_time_reg;
        last_obs_time_next = last_obs_time_reg;
        idle_since_next    = idle_since_reg;
        idle_valid_next    = idle_valid_reg;
        single_since_next  = single_since_reg;
        single_valid_next  = single_valid_reg;
        unknown_since_next = unknown_since_reg;
        unknown_valid_next = unknown_valid_reg;
        last_attempt_next  = last_attempt_reg;
        attempt_valid_next = attempt_valid_reg;
        attempt_count_next = attempt_count_reg;
        result.decision         = DEC_WAIT;
        result.attempt_accepted = 1'b0;

        case (op_t'(item.op))
            OP_START:
            begin
                running_next       = 1'b1;
                start_time_next    = now;
                last_obs_time_next = now;
                idle_valid_next    = 1'b0;
                single_valid_next  = 1'b0;
                unknown_valid_next = 1'b0;
                attempt_valid_next = 1'b0;
                attempt_count_next = '0;
                result.attempt_accepted = 1'b1;
            end
            OP_OBSERVE:
            begin
                if (!obs_ok)
                begin
                    result.decision = DEC_FAIL;
                end
                else
                begin
                    last_obs_time_next = now;
                    case (disp_t'(item.disposition))
                        DISP_EMERGENCY: result.decision = DEC_EMERGENCY;
                        DISP_MULTIPLE:  result.decision = DEC_EXTERNAL;
                        DISP_UNKNOWN:
                        begin
                            idle_valid_next    = 1'b0;
                            single_valid_next  = 1'b0;
                            unknown_valid_next = 1'b1;
                            unknown_since_next = unknown_base;
                            result.decision = unknown_ok ? DEC_UNVERIFIED : timeout_dec;
                        end
                        DISP_IDLE:
                        begin
                            single_valid_next  = 1'b0;
                            unknown_valid_next = 1'b0;
                            idle_valid_next    = 1'b1;
                            idle_since_next    = idle_base;
                            if (item.audio_normal && idle_ok)
                                result.decision = DEC_COMPLETE;
                            else if (!item.audio_normal && lag_ok)
                                result.decision = DEC_COMPLETE_LAG;
                            else
                                result.decision = timeout_dec;
                        end
                        default:
                        begin
                            idle_valid_next    = 1'b0;
                            unknown_valid_next = 1'b0;
                            single_valid_next  = 1'b1;
                            single_since_next  = single_base;
                            if (single_ok && ((attempt_count_reg == '0) ||
                                              (below_limit && retry_ok)))
                                result.decision = DEC_REQUEST;
                            else if (!below_limit && retry_ok)
                                result.decision = DEC_FAIL;
                            else
                                result.decision = timeout_dec;
                        end
                    endcase
                end
            end
            OP_RECORD:
            begin
                if (running_reg && (now >= last_obs_time_reg) && below_limit)
                begin
                    last_attempt_next  = now;
                    attempt_valid_next = 1'b1;
                    attempt_count_next = attempt_count_reg + count_t'(1);
                    result.attempt_accepted = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg       <= 1'b0;
            start_time_reg    <= '0;
            last_obs_time_reg <= '0;
            idle_since_reg    <= '0;
            idle_valid_reg    <= 1'b0;
            single_since_reg  <= '0;
            single_valid_reg  <= 1'b0;
            unknown_since_reg <= '0;
            unknown_valid_reg <= 1'b0;
            last_attempt_reg  <= '0;
            attempt_valid_reg <= 1'b0;
            attempt_count_reg <= '0;
        end
        else if (fire)
        begin
            running_reg       <= running_next;
            start_time_reg    <= start_time_next;
            last_obs_time_reg <= last_obs_time_next;
            idle_since_reg    <= idle_since_next;
            idle_valid_reg    <= idle_valid_next;
            single_since_reg  <= single_since_next;
            single_valid_reg  <= single_valid_next;
            unknown_since_reg <= unknown_since_next;
            unknown_valid_reg <= unknown_valid_next;
            last_attempt_reg  <= last_attempt_next;
            attempt_valid_reg <= attempt_valid_next;
            attempt_count_reg <= attempt_count_next;
        end
    end

    a_one_condition: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({idle_valid_reg, single_valid_reg, unknown_valid_reg}))
        else $error("more than one line condition tracked");

    a_count_has_time: assert property (@(posedge clk) disable iff (!rst_n)
        (attempt_count_reg != '0) |-> attempt_valid_reg)
        else $error("attempt counted without attempt time");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.op == OP_START)) |=> (running_reg && (attempt_count_reg == '0)))
        else $error("start did not arm supervisor");

endmodule

// ----- sv/call_recovery_supervisor.sv -----
// ----------------------------------------------------------------------------
// call_recovery_supervisor
// Phone line recovery supervisor: start, observe and hangup-attempt words in,
// one decision word out per input word.
// ----------------------------------------------------------------------------
// Takes one word per cycle while out_ready does not hold back a result:
// the word is captured in an input register, goes through one pass of
// subtract-and-compare logic against the supervisor state, and lands in the
// result register. The state updates in that same pass, so the next word in
// the input register sees it. Configuration writes take effect on the next
// cycle and must be made with no word in flight.
module call_recovery_supervisor
    import crs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      op,
    input  logic [2:0]      disposition,
    input  logic            audio_normal,
    input  time_t           now_ms,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      decision,
    output logic            attempt_accepted,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  cfg_word_t       cfg_data
);

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t result;
    cfg_t    cfg;
    logic    advance;
    logic    fire;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    assign in_valid_next  = in_ready ? in_valid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    crs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.op           <= op;
            item_reg.disposition  <= disposition;
            item_reg.audio_normal <= audio_normal;
            item_reg.now_ms       <= now_ms;
        end
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign decision         = result_reg.decision;
    assign attempt_accepted = result_reg.attempt_accepted;

    a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without a word");

    a_word_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed word lost");

    a_hold_stalled_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(item_reg)))
        else $error("stalled word dropped or changed");

endmodule

// ----- verif/call_recovery_supervisor_tb.sv -----
// ----------------------------------------------------------------------------
// call_recovery_supervisor_tb
// Self-checking bench for the phone line recovery supervisor. A scoreboard
// class keeps its own copy of the supervisor state and settings, predicts the
// decision word for every accepted input word and checks the result words in
// order. Stimulus is a directed pass over every decision path, a long run of
// hangup attempts up to the counter limit, then random sessions under small,
// zero, all-ones and full-range settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module call_recovery_supervisor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crs_pkg::*;

    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [2:0]  DISP_ALIAS  = 3'd5;
    localparam int          IDLE_PCT    = 18;
    localparam int          WORD_TARGET = 1750;
    localparam int          STALL_LIMIT = 2000;
    localparam logic [63:0] TIME_TOP    = (64'd1 << TIME_BITS) - 64'd1;

    class recovery_scoreboard;
        cfg_word_t idle_ms, lag_ms, single_ms, unknown_ms, retry_ms, total_ms;
        count_t    tries_max;
        bit        running;
        time_t     start_t, obs_t, idle_t, single_t, unknown_t, attempt_t;
        bit        idle_on, single_on, unknown_on, attempt_on;
        count_t    tries;
        result_t   verdicts[$];
        int        mismatches;
        int        checked;
        int        dec_seen[8];

        function new();
            idle_ms    = '0;
            lag_ms     = '0;
            single_ms  = '0;
            unknown_ms = 32'd1;
            retry_ms   = 32'd1;
            total_ms   = 32'd1;
            tries_max  = 8'd1;
            running    = 1'b0;
            start_t    = '0;
            obs_t      = '0;
            idle_t     = '0;
            single_t   = '0;
            unknown_t  = '0;
            attempt_t  = '0;
            idle_on    = 1'b0;
            single_on  = 1'b0;
            unknown_on = 1'b0;
            attempt_on = 1'b0;
            tries      = '0;
            mismatches = 0;
            checked    = 0;
            foreach (dec_seen[i]) dec_seen[i] = 0;
        endfunction

        function void set_reg(reg_index_t idx, cfg_word_t v);
            case (idx)
                REG_IDLE_CONFIRM:   idle_ms    = v;
                REG_AUDIO_LAG_MAX:  lag_ms     = v;
                REG_SINGLE_CONFIRM: single_ms  = v;
                REG_UNKNOWN_MAX:    unknown_ms = v;
                REG_RETRY_INTERVAL: retry_ms   = v;
                REG_TOTAL_MAX:      total_ms   = v;
                REG_MAX_ATTEMPTS:   tries_max  = v[7:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] span(time_t a, time_t b);
            return (a >= b) ? 64'(a - b) : 64'd0;
        endfunction

        function logic [63:0] floor_one(logic [63:0] v);
            return (v == 64'd0) ? 64'd1 : v;
        endfunction

        function dec_t judge_line(logic [2:0] disp, logic audio_ok, time_t now);
            logic [63:0] unk_lim, retry_lim, total_lim, try_lim, lag_lim, dur;
            bit          confirmed, retry_ok;
            unk_lim   = floor_one(64'(unknown_ms));
            retry_lim = floor_one(64'(retry_ms));
            total_lim = floor_one(64'(total_ms));
            try_lim   = floor_one(64'(tries_max));
            lag_lim   = (lag_ms > idle_ms) ? 64'(lag_ms) : 64'(idle_ms);

            if (!running || now < obs_t || now < start_t)
                return DEC_FAIL;
            obs_t = now;

            if (disp == DISP_EMERGENCY)
                return DEC_EMERGENCY;
            if (disp == DISP_MULTIPLE)
                return DEC_EXTERNAL;

            if (disp == DISP_UNKNOWN)
            begin
                idle_on   = 1'b0;
                single_on = 1'b0;
                if (!unknown_on)
                begin
                    unknown_on = 1'b1;
                    unknown_t  = now;
                end
                if (span(now, unknown_t) >= unk_lim)
                    return DEC_UNVERIFIED;
            end
            else if (disp == DISP_IDLE)
            begin
                single_on  = 1'b0;
                unknown_on = 1'b0;
                if (!idle_on)
                begin
                    idle_on = 1'b1;
                    idle_t  = now;
                end
                dur = span(now, idle_t);
                if (audio_ok && dur >= 64'(idle_ms))
                    return DEC_COMPLETE;
                if (!audio_ok && dur >= lag_lim)
                    return DEC_COMPLETE_LAG;
            end
            else
            begin
                idle_on    = 1'b0;
                unknown_on = 1'b0;
                if (!single_on)
                begin
                    single_on = 1'b1;
                    single_t  = now;
                end
                confirmed = span(now, single_t) >= 64'(single_ms);
                retry_ok  = attempt_on && (span(now, attempt_t) >= retry_lim);
                if (confirmed && (tries == 0 || (64'(tries) < try_lim && retry_ok)))
                    return DEC_REQUEST;
                if (64'(tries) >= try_lim && retry_ok)
                    return DEC_FAIL;
            end

            return (span(now, start_t) >= total_lim) ? DEC_FAIL : DEC_WAIT;
        endfunction

        function void note_word(logic [1:0] op, logic [2:0] disp, logic audio, time_t now);
            result_t r;
            r.decision         = DEC_WAIT;
            r.attempt_accepted = 1'b0;
            case (op)
                OP_START:
                begin
                    running    = 1'b1;
                    start_t    = now;
                    obs_t      = now;
                    idle_on    = 1'b0;
                    single_on  = 1'b0;
                    unknown_on = 1'b0;
                    attempt_on = 1'b0;
                    tries      = '0;
                    r.attempt_accepted = 1'b1;
                end
                OP_OBSERVE:
                    r.decision = judge_line(disp, audio, now);
                OP_RECORD:
                begin
                    if (running && now >= obs_t && 64'(tries) < floor_one(64'(tries_max)))
                    begin
                        attempt_t  = now;
                        attempt_on = 1'b1;
                        tries      = tries + 8'd1;
                        r.attempt_accepted = 1'b1;
                    end
                end
                default: ;
            endcase
            dec_seen[int'(r.decision)]++;
            verdicts.push_back(r);
        endfunction

        function void check_word(logic [2:0] dec, logic acc);
            result_t want;
            if (verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: decision %0d accepted %0d", dec, acc);
                return;
            end
            want = verdicts.pop_front();
            checked++;
            if (dec !== want.decision || acc !== want.attempt_accepted)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch on result %0d: decision exp %0d got %0d, ",
                              "accepted exp %0d got %0d"},
                             checked, want.decision, dec, want.attempt_accepted, acc);
            end
        endfunction

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n            = 1'b0;
    logic       in_valid         = 1'b0;
    logic       in_ready;
    logic [1:0] op               = '0;
    logic [2:0] disposition      = '0;
    logic       audio_normal     = 1'b0;
    time_t      now_ms           = '0;
    logic       out_valid;
    logic       out_ready        = 1'b0;
    logic [2:0] decision;
    logic       attempt_accepted;
    logic       cfg_we           = 1'b0;
    logic [2:0] cfg_index        = '0;
    cfg_word_t  cfg_data         = '0;

    int         cyc              = 0;
    int         words            = 0;
    int         settings         = 0;
    int         stall            = 0;
    recovery_scoreboard sb;

    call_recovery_supervisor uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .disposition      (disposition),
        .audio_normal     (audio_normal),
        .now_ms           (now_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .decision         (decision),
        .attempt_accepted (attempt_accepted),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit calm();
        return cyc >= 1200 && cyc < 1700;
    endfunction

    function automatic time_t fresh_time();
        return time_t'({$urandom, $urandom});
    endfunction

    always @(posedge clk)
    begin
        cyc       <= cyc + 1;
        out_ready <= calm() || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(decision, attempt_accepted);
    end

    initial
    begin
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall = 0;
            else
                stall++;
        end
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_word(logic [1:0] w_op, logic [2:0] w_disp, logic w_audio, time_t w_now);
        while (!calm() && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= w_op;
        disposition  <= w_disp;
        audio_normal <= w_audio;
        now_ms       <= w_now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_word(w_op, w_disp, w_audio, w_now);
        words++;
    endtask

    // drop valid and wait out every word still in flight
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, cfg_word_t v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic load_settings(cfg_t c);
        settle();
        write_reg(REG_IDLE_CONFIRM,   c.idle_confirm);
        write_reg(REG_AUDIO_LAG_MAX,  c.audio_lag);
        write_reg(REG_SINGLE_CONFIRM, c.single_confirm);
        write_reg(REG_UNKNOWN_MAX,    c.unknown_max);
        write_reg(REG_RETRY_INTERVAL, c.retry_interval);
        write_reg(REG_TOTAL_MAX,      c.total_max);
        write_reg(REG_MAX_ATTEMPTS,   cfg_word_t'(c.max_attempts));
        cfg_we <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    initial
    begin
        time_t       t, stamp;
        logic [63:0] step;
        logic [1:0]  op_pick;
        logic [2:0]  disp;
        cfg_t        plan;
        int          kind, n, roll, scale, k;

        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: words before any start, unused code, zero thresholds
        send_word(OP_OBSERVE, DISP_IDLE, 1'b1, '0);
        send_word(OP_RECORD, DISP_IDLE, 1'b0, '0);
        send_word(OP_UNUSED, DISP_EMERGENCY, 1'b1, '1);
        send_word(OP_START, DISP_IDLE, 1'b0, '0);
        send_word(OP_OBSERVE, DISP_IDLE, 1'b1, '0);

        plan.idle_confirm   = 32'd5;
        plan.audio_lag      = 32'd12;
        plan.single_confirm = 32'd3;
        plan.unknown_max    = 32'd4;
        plan.retry_interval = 32'd6;
        plan.total_max      = 32'd1000;
        plan.max_attempts   = 8'd2;
        load_settings(plan);

        send_word(OP_START, DISP_SINGLE, 1'b1, 1000);
        send_word(OP_OBSERVE, DISP_IDLE, 1'b1, 1000);
        send_word(OP_OBSERVE, DISP_IDLE, 1'b1, 1005);
        send_word(OP_OBSERVE, DISP_IDLE, 1'b0, 1010);
        send_word(OP_OBSERVE, DISP_IDLE, 1'b0, 1012);
        send_word(OP_OBSERVE, DISP_SINGLE, 1'b1, 1013);
        send_word(OP_OBSERVE, DISP_SINGLE, 1'b1, 1016);
        send_word(OP_RECORD, DISP_SINGLE, 1'b1, 1016);
        send_word(OP_OBSERVE, DISP_SINGLE, 1'b0, 1018);
        send_word(OP_OBSERVE, DISP_SINGLE, 1'b1, 1022);
        send_word(OP_RECORD, DISP_SINGLE, 1'b1, 1022);
        send_word(OP_RECORD, DISP_SINGLE, 1'b1, 1023);
        send_word(OP_OBSERVE, DISP_SINGLE, 1'b1, 1028);
        send_word(OP_OBSERVE, DISP_ALIAS, 1'b1, 1029);
        send_word(OP_OBSERVE, DISP_UNKNOWN, 1'b1, 1030);
        send_word(OP_OBSERVE, DISP_UNKNOWN, 1'b0, 1034);
        send_word(OP_OBSERVE, DISP_MULTIPLE, 1'b1, 1035);
        send_word(OP_OBSERVE, DISP_EMERGENCY, 1'b1, 1036);
        send_word(OP_OBSERVE, DISP_IDLE, 1'b1, 1020);
        send_word(OP_RECORD, DISP_IDLE, 1'b1, 1020);
        send_word(OP_OBSERVE, DISP_IDLE, 1'b1, 2100);
        // attempt stamped later than the next observation
        send_word(OP_START, DISP_IDLE, 1'b1, 2200);
        send_word(OP_RECORD, DISP_IDLE, 1'b1, 3000);
        send_word(OP_OBSERVE, DISP_SINGLE, 1'b1, 2500);
        send_word(OP_START, DISP_SINGLE, 1'b0, '1);
        send_word(OP_OBSERVE, DISP_IDLE, 1'b1, '1);

        // run the attempt counter to its widest limit and one past it
        plan.idle_confirm   = 32'd3;
        plan.audio_lag      = 32'd3;
        plan.single_confirm = '0;
        plan.unknown_max    = 32'd5;
        plan.retry_interval = 32'd1;
        plan.total_max      = '1;
        plan.max_attempts   = '1;
        load_settings(plan);
        send_word(OP_START, DISP_IDLE, 1'b0, 5000);
        for (k = 1; k <= 256; k++)
            send_word(OP_RECORD, DISP_SINGLE, 1'b1, time_t'(5000 + k));
        send_word(OP_OBSERVE, DISP_SINGLE, 1'b1, 5300);
        send_word(OP_OBSERVE, DISP_SINGLE, 1'b0, 5301);

        kind = 0;
        while (words < WORD_TARGET)
        begin
            case (kind % 5)
                1:
                begin
                    plan  = '0;
                    scale = 4;
                end
                2:
                begin
                    plan  = '1;
                    scale = 40;
                end
                3:
                begin
                    plan.idle_confirm   = $urandom;
                    plan.audio_lag      = $urandom;
                    plan.single_confirm = $urandom;
                    plan.unknown_max    = $urandom;
                    plan.retry_interval = $urandom;
                    plan.total_max      = $urandom;
                    plan.max_attempts   = 8'($urandom_range(0, 255));
                    scale = 200;
                end
                default:
                begin
                    plan.idle_confirm   = $urandom_range(0, 30);
                    plan.audio_lag      = $urandom_range(0, 60);
                    plan.single_confirm = $urandom_range(0, 20);
                    plan.unknown_max    = $urandom_range(0, 30);
                    plan.retry_interval = $urandom_range(0, 20);
                    plan.total_max      = $urandom_range(20, 3000);
                    plan.max_attempts   = 8'($urandom_range(0, 5));
                    if (kind % 5 == 4)
                        plan.total_max = '1;
                    scale = 40;
                end
            endcase
            load_settings(plan);

            t = fresh_time();
            send_word(OP_START, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), t);
            disp = 3'($urandom_range(0, 7));
            for (n = 1; n < 120; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    op_pick = OP_START;
                else if (roll < 72)
                    op_pick = OP_OBSERVE;
                else if (roll < 94)
                    op_pick = OP_RECORD;
                else if (roll < 97)
                    op_pick = OP_UNUSED;
                else
                    op_pick = OP_OBSERVE;

                if ($urandom_range(0, 99) < 25)
                    disp = 3'($urandom_range(0, 7));

                if (op_pick == OP_START && $urandom_range(0, 1) == 1)
                begin
                    t     = fresh_time();
                    stamp = t;
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 5)
                    begin
                        step  = 64'($urandom_range(1, scale));
                        stamp = (64'(t) > step) ? time_t'(64'(t) - step) : '0;
                    end
                    else
                    begin
                        if (roll < 15)
                            step = 64'd0;
                        else if (roll < 85)
                            step = 64'($urandom_range(1, scale));
                        else if (roll < 93)
                            step = 64'($urandom);
                        else
                            step = 64'($urandom) << $urandom_range(0, 16);
                        t = (64'(t) + step > TIME_TOP) ? '1 : time_t'(64'(t) + step);
                        stamp = t;
                    end
                end
                send_word(op_pick, disp, 1'($urandom_range(0, 1)), stamp);
            end
            kind++;
        end

        settle();
        repeat (6) @(posedge clk);

        $display("covered %0d words over %0d settings, %0d results checked, %0d mismatches",
                 words, settings, sb.checked, sb.mismatches);
        $display("decisions: wait %0d request %0d complete %0d lag %0d emergency %0d",
                 sb.dec_seen[0], sb.dec_seen[1], sb.dec_seen[2], sb.dec_seen[3],
                 sb.dec_seen[4]);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
        begin
            if (sb.pending() != 0)
                $display("%0d result words never arrived", sb.pending());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
